// ----- hw/rtl/irft_pkg.sv -----
// Shared types and constants for the infrared remote frame transmitter.
package irft_pkg;

  localparam int MAX_BYTES = 16;
  localparam int STORE_AW  = $clog2(MAX_BYTES);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] byte_index;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic ir_out;
    logic busy_res;
    logic frame_done;
  } res_t;

endpackage

// ----- hw/rtl/ir_remote_frame_transmitter.sv -----
// Infrared remote frame transmitter: frame store, segment sequencer, carrier and result skid.
//
// Every request (byte load, frame start or one-microsecond tick) returns one result with the LED
// level for that tick, the busy flag and the frame-done flag. The result is registered and is
// offered on the cycle after the request is taken if the output is free, else it waits in the
// skid stage. A request is taken in every cycle; requests stall only while both the result
// register and the skid stage hold results that the sink has not yet taken. The 16-byte frame
// store is a synchronous memory that is read every cycle at the byte of the bit the sequencer
// will use next, so the bit value is ready by the first tick of each bit. Loads and starts
// during a frame are ignored. Configuration writes are always ready and take effect at once.
module ir_remote_frame_transmitter (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  irft_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output irft_pkg::res_t res,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [11:0]   cfg_data
);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_LEAD_MARK  = 3'd1;
  localparam logic [2:0] PH_LEAD_SPACE = 3'd2;
  localparam logic [2:0] PH_BIT_FIRST  = 3'd3;
  localparam logic [2:0] PH_BIT_SECOND = 3'd4;

  localparam logic [2:0] CFG_MODE        = 3'd0;
  localparam logic [2:0] CFG_UNIT        = 3'd1;
  localparam logic [2:0] CFG_LEAD_MARK   = 3'd2;
  localparam logic [2:0] CFG_LEAD_SPACE  = 3'd3;
  localparam logic [2:0] CFG_CARRIER_ON  = 3'd4;
  localparam logic [2:0] CFG_CARRIER_OFF = 3'd5;
  localparam logic [2:0] CFG_BIT_COUNT   = 3'd6;

  // configuration registers
  logic        mode;
  logic [11:0] unit_us;
  logic [4:0]  leader_mark_units;
  logic [4:0]  leader_space_units;
  logic [7:0]  carrier_on_us;
  logic [7:0]  carrier_off_us;
  logic [7:0]  bit_count;

  // sequencer state
  logic [2:0]  phase, phase_next;
  logic [6:0]  bit_pos, bit_pos_next;
  logic [16:0] time_left, time_left_next;
  logic [7:0]  carrier_count, carrier_count_next;
  logic        carrier_level, carrier_level_next;

  // frame store
  localparam int MAX_BYTES_L = irft_pkg::MAX_BYTES;
  logic [7:0]  frame_store [MAX_BYTES_L];
  logic [7:0]  rd_byte;
  logic        rd_in_range;
  logic [3:0]  rd_sel;
  logic        wr_en;

  // result path
  irft_pkg::res_t result, skid;
  logic        skid_valid;
  logic        cmd_take;
  logic        res_take;

  logic [11:0] unit_t;
  logic [7:0]  bits_in_frame;
  logic [7:0]  carrier_on_t;
  logic [7:0]  carrier_off_t;
  logic [16:0] lead_mark_len;
  logic [16:0] lead_space_len;
  logic [16:0] bit_second_len;
  logic [16:0] time_dec;
  logic [7:0]  count_dec;
  logic        cur_bit;
  logic        entered;
  logic        is_idle;

  function automatic logic phase_is_mark(input logic [2:0] ph, input logic md);
    logic m;
    m = 1'b0;
    if (ph == PH_LEAD_MARK) m = 1'b1;
    if (ph == PH_BIT_FIRST && !md) m = 1'b1;
    if (ph == PH_BIT_SECOND && md) m = 1'b1;
    return m;
  endfunction

  assign cfg_ready = 1'b1;
  assign cmd_stall = skid_valid;
  assign cmd_take  = cmd_valid && !skid_valid;
  assign res_take  = res_valid && !res_stall;
  assign is_idle   = (phase == PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= 1'b0;
      unit_us            <= 12'd562;
      leader_mark_units  <= 5'd16;
      leader_space_units <= 5'd8;
      carrier_on_us      <= 8'd9;
      carrier_off_us     <= 8'd17;
      bit_count          <= 8'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:        mode               <= cfg_data[0];
        CFG_UNIT:        unit_us            <= cfg_data;
        CFG_LEAD_MARK:   leader_mark_units  <= cfg_data[4:0];
        CFG_LEAD_SPACE:  leader_space_units <= cfg_data[4:0];
        CFG_CARRIER_ON:  carrier_on_us      <= cfg_data[7:0];
        CFG_CARRIER_OFF: carrier_off_us     <= cfg_data[7:0];
        CFG_BIT_COUNT:   bit_count          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // derived timing
  always_comb begin
    unit_t         = (unit_us == 12'd0) ? 12'd1 : unit_us;
    bits_in_frame  = (bit_count > 8'd128) ? 8'd128 : bit_count;
    carrier_on_t   = (carrier_on_us == 8'd0) ? 8'd1 : carrier_on_us;
    carrier_off_t  = (carrier_off_us == 8'd0) ? 8'd1 : carrier_off_us;
    lead_mark_len  = 17'(leader_mark_units) * 17'(unit_t);
    lead_space_len = 17'(leader_space_units) * 17'(unit_t);
    cur_bit        = rd_in_range && rd_byte[bit_pos[2:0]];
    if (!cur_bit) begin
      bit_second_len = 17'(unit_t);
    end else if (mode) begin
      bit_second_len = 17'({unit_t, 1'b0});
    end else begin
      bit_second_len = 17'({unit_t, 1'b0}) + 17'(unit_t);
    end
    time_dec  = (time_left != 17'd0) ? time_left - 17'd1 : 17'd0;
    count_dec = (carrier_count != 8'd0) ? carrier_count - 8'd1 : 8'd0;
  end

  always_comb begin
    phase_next         = phase;
    bit_pos_next       = bit_pos;
    time_left_next     = time_left;
    carrier_count_next = carrier_count;
    carrier_level_next = carrier_level;
    entered            = 1'b0;
    wr_en              = 1'b0;
    result             = '0;
    unique case (cmd.req_type)
      irft_pkg::REQ_LOAD: begin
        wr_en = is_idle && (32'(cmd.byte_index) < irft_pkg::MAX_BYTES);
      end
      irft_pkg::REQ_START: begin
        if (is_idle) begin
          entered      = 1'b1;
          bit_pos_next = 7'd0;
          // skip leader parts of zero length
          if (lead_mark_len != 17'd0) begin
            phase_next     = PH_LEAD_MARK;
            time_left_next = lead_mark_len;
          end else if (lead_space_len != 17'd0) begin
            phase_next     = PH_LEAD_SPACE;
            time_left_next = lead_space_len;
          end else if (bits_in_frame == 8'd0) begin
            phase_next     = PH_IDLE;
            time_left_next = 17'd0;
          end else begin
            phase_next     = PH_BIT_FIRST;
            time_left_next = 17'(unit_t);
          end
        end
      end
      irft_pkg::REQ_TICK: begin
        if (!is_idle) begin
          if (phase_is_mark(phase, mode)) begin
            result.ir_out = carrier_level;
            if (count_dec == 8'd0) begin
              carrier_level_next = !carrier_level;
              carrier_count_next = carrier_level ? carrier_off_t : carrier_on_t;
            end else begin
              carrier_count_next = count_dec;
            end
          end
          if (time_dec != 17'd0) begin
            time_left_next = time_dec;
          end else begin
            entered = 1'b1;
            unique case (phase)
              PH_LEAD_MARK: begin
                if (lead_space_len != 17'd0) begin
                  phase_next     = PH_LEAD_SPACE;
                  time_left_next = lead_space_len;
                end else if (bits_in_frame == 8'd0) begin
                  phase_next     = PH_IDLE;
                  time_left_next = 17'd0;
                end else begin
                  phase_next     = PH_BIT_FIRST;
                  time_left_next = 17'(unit_t);
                  bit_pos_next   = 7'd0;
                end
              end
              PH_LEAD_SPACE: begin
                if (bits_in_frame == 8'd0) begin
                  phase_next     = PH_IDLE;
                  time_left_next = 17'd0;
                end else begin
                  phase_next     = PH_BIT_FIRST;
                  time_left_next = 17'(unit_t);
                  bit_pos_next   = 7'd0;
                end
              end
              PH_BIT_FIRST: begin
                phase_next     = PH_BIT_SECOND;
                time_left_next = bit_second_len;
              end
              PH_BIT_SECOND: begin
                if ({1'b0, bit_pos} + 8'd1 >= bits_in_frame) begin
                  phase_next     = PH_IDLE;
                  time_left_next = 17'd0;
                end else begin
                  phase_next     = PH_BIT_FIRST;
                  time_left_next = 17'(unit_t);
                  bit_pos_next   = bit_pos + 7'd1;
                end
              end
              default: begin
                phase_next     = PH_IDLE;
                time_left_next = 17'd0;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    // restart the carrier lit at the start of every mark
    if (entered && phase_is_mark(phase_next, mode)) begin
      carrier_level_next = 1'b1;
      carrier_count_next = carrier_on_t;
    end
    result.busy_res   = (phase_next != PH_IDLE);
    result.frame_done = entered && (phase_next == PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_pos       <= 7'd0;
      time_left     <= 17'd0;
      carrier_count <= 8'd0;
      carrier_level <= 1'b0;
    end else if (cmd_take) begin
      phase         <= phase_next;
      bit_pos       <= bit_pos_next;
      time_left     <= time_left_next;
      carrier_count <= carrier_count_next;
      carrier_level <= carrier_level_next;
    end
  end

  // read the byte of the bit that will be current next cycle; forward a same-address load
  assign rd_sel = cmd_take ? bit_pos_next[6:3] : bit_pos[6:3];

  always_ff @(posedge clk) begin
    if (cmd_take && wr_en) begin
      frame_store[cmd.byte_index[irft_pkg::STORE_AW-1:0]] <= cmd.data_byte;
    end
    if (cmd_take && wr_en && (cmd.byte_index == rd_sel)) begin
      rd_byte <= cmd.data_byte;
    end else begin
      rd_byte <= frame_store[rd_sel[irft_pkg::STORE_AW-1:0]];
    end
    rd_in_range <= (32'(rd_sel) < irft_pkg::MAX_BYTES);
  end

  // result register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_take) begin
      res_valid  <= skid_valid || cmd_take;
      skid_valid <= 1'b0;
    end else if (cmd_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || res_take) begin
      res <= skid_valid ? skid : result;
    end else if (cmd_take) begin
      skid <= result;
    end
  end

endmodule

// ----- hw/rtl/irft_checker.sv -----
// Port-level checker for the infrared remote frame transmitter, bound to the top level.
module irft_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           res_valid,
  input logic           res_stall,
  input irft_pkg::res_t res
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a stalled request means a result is waiting at the output
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid)
    else $error("request stalled with no result pending");

  // an accepted request always leaves a result valid at the output next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> res_valid)
    else $error("accepted request produced no result");

  // a finished frame is no longer busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.frame_done) |-> !res.busy_res)
    else $error("frame done while still busy");

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

endmodule

bind ir_remote_frame_transmitter irft_checker u_irft_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the infrared remote frame transmitter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_REQUESTS = 50;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int REG_MODE       = 0;
  localparam int REG_UNIT       = 1;
  localparam int REG_LEAD_MARK  = 2;
  localparam int REG_LEAD_SPACE = 3;
  localparam int REG_CARRIER_ON = 4;
  localparam int REG_CARRIER_OFF = 5;
  localparam int REG_BIT_COUNT  = 6;
  localparam int REG_COUNT      = 7;

  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_LEAD_MARK,
    SEG_LEAD_SPACE,
    SEG_BIT_FIRST,
    SEG_BIT_SECOND
  } seg_e;

  typedef struct {
    bit        mode;
    bit [11:0] unit_us;
    bit [4:0]  lead_mark;
    bit [4:0]  lead_space;
    bit [7:0]  car_on;
    bit [7:0]  car_off;
    bit [7:0]  bit_count;
  } setup_t;

  logic           clk;
  logic           rst = 1'b1;
  logic           cmd_valid = 1'b0;
  logic           cmd_stall;
  irft_pkg::cmd_t cmd = '0;
  logic           res_valid;
  logic           res_stall = 1'b0;
  irft_pkg::res_t res;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [2:0]     cfg_index = '0;
  logic [11:0]    cfg_data = '0;

  // Transmitter state as the testbench sees it
  setup_t      active_setup;
  bit [7:0]    frame_bytes [irft_pkg::MAX_BYTES];
  seg_e        seg;
  bit [6:0]    bitpos;
  bit [16:0]   remain;
  bit [7:0]    car_cnt;
  bit          car_lvl;

  irft_pkg::res_t results_due [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned useful_count;
  int unsigned stall_run;
  bit          calm;

  ir_remote_frame_transmitter uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL ir_remote_frame_transmitter");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Transmitter behavior
  // ---------------------------------------------------------------------------
  function automatic bit [7:0] nonzero8(bit [7:0] v);
    return (v == 0) ? 8'd1 : v;
  endfunction

  function automatic int unsigned unit_len();
    return (active_setup.unit_us == 0) ? 1 : active_setup.unit_us;
  endfunction

  function automatic int unsigned frame_bits();
    return (active_setup.bit_count > 128) ? 128 : active_setup.bit_count;
  endfunction

  function automatic bit is_mark(seg_e s);
    case (s)
      SEG_LEAD_MARK:  return 1'b1;
      SEG_BIT_FIRST:  return !active_setup.mode;
      SEG_BIT_SECOND: return active_setup.mode;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic void enter_seg(seg_e s, int unsigned len);
    seg = s;
    remain = 17'(len);
    // every mark restarts the carrier lit
    if (is_mark(s)) begin
      car_lvl = 1'b1;
      car_cnt = nonzero8(active_setup.car_on);
    end
  endfunction

  function automatic void next_seg();
    int unsigned t;
    bit          one;
    t = unit_len();
    one = frame_bytes[bitpos[6:3]][bitpos[2:0]];
    case (seg)
      SEG_LEAD_MARK: enter_seg(SEG_LEAD_SPACE, active_setup.lead_space * t);
      SEG_LEAD_SPACE: begin
        if (frame_bits() == 0) begin
          enter_seg(SEG_IDLE, 0);
        end else begin
          bitpos = '0;
          enter_seg(SEG_BIT_FIRST, t);
        end
      end
      SEG_BIT_FIRST: enter_seg(SEG_BIT_SECOND, !one ? t : (active_setup.mode ? 2 * t : 3 * t));
      SEG_BIT_SECOND: begin
        if (bitpos + 1 >= frame_bits()) begin
          enter_seg(SEG_IDLE, 0);
        end else begin
          bitpos = 7'(bitpos + 1);
          enter_seg(SEG_BIT_FIRST, t);
        end
      end
      default: enter_seg(SEG_IDLE, 0);
    endcase
  endfunction

  // Skip empty segments; report whether the frame is over
  function automatic bit settle();
    while (seg != SEG_IDLE && remain == 0) next_seg();
    return seg == SEG_IDLE;
  endfunction

  function automatic irft_pkg::res_t transmitter_response(irft_pkg::cmd_t c);
    irft_pkg::res_t r;
    bit   led;
    bit   done;
    led = 1'b0;
    done = 1'b0;
    case (c.req_type)
      irft_pkg::REQ_LOAD: begin
        if (seg == SEG_IDLE) frame_bytes[c.byte_index] = c.data_byte;
      end
      irft_pkg::REQ_START: begin
        if (seg == SEG_IDLE) begin
          bitpos = '0;
          enter_seg(SEG_LEAD_MARK, active_setup.lead_mark * unit_len());
          done = settle();
        end
      end
      irft_pkg::REQ_TICK: begin
        if (seg != SEG_IDLE) begin
          if (is_mark(seg)) begin
            led = car_lvl;
            if (car_cnt != 0) car_cnt--;
            if (car_cnt == 0) begin
              car_lvl = ~car_lvl;
              car_cnt = nonzero8(car_lvl ? active_setup.car_on : active_setup.car_off);
            end
          end
          if (remain != 0) remain--;
          if (remain == 0) begin
            next_seg();
            done = settle();
          end
        end
      end
      default: ;
    endcase
    r.ir_out = led;
    r.busy_res = (seg != SEG_IDLE);
    r.frame_done = done;
    return r;
  endfunction

  function automatic void reset_transmitter_state();
    active_setup = '{mode: 1'b0, unit_us: 12'd562, lead_mark: 5'd16, lead_space: 5'd8,
                     car_on: 8'd9, car_off: 8'd17, bit_count: 8'd32};
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    seg = SEG_IDLE;
    bitpos = '0;
    remain = '0;
    car_cnt = '0;
    car_lvl = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshakes and result checking
  // ---------------------------------------------------------------------------
  function automatic int unsigned pause_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst || calm) begin
      res_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      res_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      res_stall <= 1'b0;
      if ($urandom_range(0, 99) < 12) stall_run <= pause_len();
    end
  end

  always @(posedge clk) begin : check_results
    irft_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (results_due.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("cycle %0d: result with nothing due: ir_out=%b busy=%b done=%b",
                   cycle_count, res.ir_out, res.busy_res, res.frame_done);
      end else begin
        want = results_due.pop_front();
        if (res.ir_out !== want.ir_out || res.busy_res !== want.busy_res ||
            res.frame_done !== want.frame_done) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("cycle %0d: expected ir_out=%b busy=%b done=%b, got ir_out=%b busy=%b done=%b",
                     cycle_count, want.ir_out, want.busy_res, want.frame_done,
                     res.ir_out, res.busy_res, res.frame_done);
        end
      end
    end
  end

  task automatic send_request(input logic [1:0] kind, input logic [3:0] idx,
                              input logic [7:0] dat);
    irft_pkg::cmd_t c;
    int unsigned    gap;
    c.req_type = kind;
    c.byte_index = idx;
    c.data_byte = dat;
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : pause_len();
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (seg == SEG_IDLE ? (kind == irft_pkg::REQ_LOAD || kind == irft_pkg::REQ_START)
                        : (kind == irft_pkg::REQ_TICK))
      useful_count++;
    results_due.push_back(transmitter_response(c));
  endtask

  task automatic send_plain(input logic [1:0] kind);
    send_request(kind, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [1:0] stray_kind();
    case ($urandom_range(0, 2))
      0:       return irft_pkg::REQ_LOAD;
      1:       return irft_pkg::REQ_START;
      default: return REQ_UNKNOWN;
    endcase
  endfunction

  // Hold requests until every result is back
  task automatic drain_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  function automatic logic [11:0] reg_value(setup_t s, int r);
    case (r)
      REG_MODE:        return 12'(s.mode);
      REG_UNIT:        return s.unit_us;
      REG_LEAD_MARK:   return 12'(s.lead_mark);
      REG_LEAD_SPACE:  return 12'(s.lead_space);
      REG_CARRIER_ON:  return 12'(s.car_on);
      REG_CARRIER_OFF: return 12'(s.car_off);
      default:         return 12'(s.bit_count);
    endcase
  endfunction

  // Write all registers; call only with nothing in flight
  task automatic apply_setup(setup_t s);
    for (int r = 0; r < REG_COUNT; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data <= reg_value(s, r);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    active_setup = s;
  endtask

  function automatic setup_t make_setup(bit mode, int unsigned unit, int unsigned lm,
                                        int unsigned ls, int unsigned on, int unsigned off,
                                        int unsigned nb);
    setup_t s;
    s.mode = mode;
    s.unit_us = 12'(unit);
    s.lead_mark = 5'(lm);
    s.lead_space = 5'(ls);
    s.car_on = 8'(on);
    s.car_off = 8'(off);
    s.bit_count = 8'(nb);
    return s;
  endfunction

  function automatic setup_t random_setup();
    setup_t      s;
    int unsigned pick;
    s.mode = 1'($urandom_range(0, 1));
    s.unit_us = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 2));
    s.lead_mark = 5'($urandom_range(0, 4));
    s.lead_space = 5'($urandom_range(0, 3));
    s.car_on = 8'($urandom_range(0, 4));
    s.car_off = 8'($urandom_range(0, 4));
    pick = $urandom_range(0, 99);
    s.bit_count = (pick < 10) ? 8'd0 : 8'($urandom_range(1, 12));
    return s;
  endfunction

  // Start a frame and tick until it ends; optionally mix in ignored requests
  task automatic run_frame(input bit noisy);
    send_plain(irft_pkg::REQ_START);
    while (seg != SEG_IDLE) begin
      if (noisy && $urandom_range(0, 11) == 0) send_plain(stray_kind());
      else send_plain(irft_pkg::REQ_TICK);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_store_fill();
    logic [7:0] v;
    for (int i = 0; i < irft_pkg::MAX_BYTES; i++) begin
      case (i)
        0:       v = 8'h00;
        1:       v = 8'hFF;
        2:       v = 8'hA5;
        3:       v = 8'h5A;
        default: v = 8'($urandom_range(0, 255));
      endcase
      send_request(irft_pkg::REQ_LOAD, 4'(i), v);
    end
    send_request(irft_pkg::REQ_TICK, 4'hF, 8'hFF);
    send_request(REQ_UNKNOWN, 4'hF, 8'hFF);
  endtask

  task automatic test_pulse_distance();
    drain_results();
    apply_setup(make_setup(1'b0, 1, 2, 1, 1, 1, 16));
    run_frame(1'b1);
  endtask

  task automatic test_pulse_width();
    drain_results();
    apply_setup(make_setup(1'b1, 1, 3, 0, 1, 255, 12));
    run_frame(1'b1);
  endtask

  task automatic test_degenerate_settings();
    // zero unit and carrier times, no data bits: frame is just the leader
    drain_results();
    apply_setup(make_setup(1'b0, 0, 2, 1, 0, 0, 0));
    run_frame(1'b0);
    // nothing to send: the start itself finishes the frame
    drain_results();
    apply_setup(make_setup(1'b1, 1, 0, 0, 3, 2, 0));
    send_plain(irft_pkg::REQ_START);
    send_plain(irft_pkg::REQ_TICK);
    // no leader: go straight to the data bits
    drain_results();
    apply_setup(make_setup(1'b0, 1, 0, 0, 2, 2, 3));
    run_frame(1'b0);
    // bit count past the store size is clamped to all sixteen bytes
    drain_results();
    apply_setup(make_setup(1'b1, 1, 1, 0, 1, 255, 255));
    run_frame(1'b0);
  endtask

  task automatic test_long_leader();
    drain_results();
    apply_setup(make_setup(1'b1, 1, 31, 0, 255, 1, 1));
    calm = 1'b1;
    run_frame(1'b0);
    calm = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned first;
    first = useful_count;
    while (useful_count - first < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
        apply_setup(random_setup());
      end
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(0, 6))
        send_request(irft_pkg::REQ_LOAD, 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
        send_plain($urandom_range(0, 1) ? irft_pkg::REQ_TICK : REQ_UNKNOWN);
      run_frame(1'b1);
      calm = 1'b0;
    end
  endtask

  initial begin
    reset_transmitter_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_store_fill();
    test_pulse_distance();
    test_pulse_width();
    test_degenerate_settings();
    test_long_leader();
    test_random_frames();
    cmd_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS ir_remote_frame_transmitter");
    end else begin
      $display("FAIL ir_remote_frame_transmitter");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/irft_pkg.sv
hw/rtl/ir_remote_frame_transmitter.sv
hw/rtl/irft_checker.sv
tb/tb_top.sv
